// ===== rtl/pdlz_pkg.sv =====
`timescale 1ns / 1ps

package pdlz_pkg;

    localparam int WINDOW_DEPTH = 2048;
    localparam int HIST_AW      = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = HIST_AW + 1;

    localparam logic [CNT_W-1:0] PROD_MAX   = CNT_W'(WINDOW_DEPTH);
    localparam logic [7:0]       SPACE_BYTE = 8'h20;
    localparam logic [7:0]       XOR_MASK   = 8'h80;
    localparam logic [7:0]       LIT_LOW    = 8'h09;
    localparam logic [7:0]       LIT_HIGH   = 8'h7f;
    localparam logic [7:0]       SPACE_LOW  = 8'hc0;
    localparam logic [3:0]       RUN_MAX    = 4'd8;
    localparam logic [3:0]       MIN_LEN    = 4'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SECOND,
        S_COPY,
        S_ERROR
    } t_state;

    typedef enum logic [2:0] {
        SRC_IN,
        SRC_SPACE,
        SRC_XOR,
        SRC_HIST,
        SRC_ERR
    } t_src;

    typedef enum logic [2:0] {
        CLS_STOPPED,
        CLS_PAIR2,
        CLS_RAW,
        CLS_LIT,
        CLS_RUN,
        CLS_SPACE,
        CLS_PAIR1
    } t_cls;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_TRUNC = 2'd1,
        STAT_DIST  = 2'd2
    } t_status;

    typedef struct packed {
        logic    load_in;
        logic    emit;
        t_src    src;
        logic    lor;
        logic    rend;
        logic    raw_set;
        logic    raw_dec;
        logic    pair_set;
        logic    pair_clr;
        logic    err_set;
        t_status err_code;
        logic    stop_set;
        logic    close;
        logic    copy_start;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        t_cls cls;
        logic last;
        logic dist_bad;
        logic raw_more;
        logic copy_last;
    } t_dp_sts;

endpackage

// ===== rtl/pdlz_ram.sv =====
`timescale 1ns / 1ps

module pdlz_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pdlz_ctrl.sv =====
`timescale 1ns / 1ps

module pdlz_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  pdlz_pkg::t_dp_sts i_sts,
    output pdlz_pkg::t_dp_cmd o_cmd
);
    import pdlz_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.out_free) begin
                    unique case (i_sts.cls)
                        CLS_PAIR2: n_state = i_sts.dist_bad ? S_ERROR : S_COPY;
                        CLS_RAW:   n_state = (i_sts.last && i_sts.raw_more) ? S_ERROR : S_IDLE;
                        CLS_RUN:   n_state = i_sts.last ? S_ERROR : S_IDLE;
                        CLS_PAIR1: n_state = i_sts.last ? S_ERROR : S_IDLE;
                        CLS_SPACE: n_state = S_SECOND;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_SECOND: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_COPY: begin
                if (i_sts.out_free && i_sts.copy_last) begin
                    n_state = S_IDLE;
                end
            end
            S_ERROR: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        o_cmd          = '0;
        o_cmd.src      = SRC_IN;
        o_cmd.err_code = STAT_OK;
        o_cmd.load_in  = (r_state == S_IDLE) && i_in_valid;
        unique case (r_state)
            S_IDLE: begin
            end
            S_DECODE: begin
                if (i_sts.out_free) begin
                    unique case (i_sts.cls)
                        CLS_STOPPED: begin
                            o_cmd.close = i_sts.last;
                        end
                        CLS_PAIR2: begin
                            o_cmd.pair_clr = 1'b1;
                            if (i_sts.dist_bad) begin
                                o_cmd.err_set  = 1'b1;
                                o_cmd.err_code = STAT_DIST;
                            end else begin
                                o_cmd.copy_start = 1'b1;
                            end
                        end
                        CLS_RAW: begin
                            o_cmd.emit    = 1'b1;
                            o_cmd.src     = SRC_IN;
                            o_cmd.raw_dec = 1'b1;
                            if (i_sts.last && i_sts.raw_more) begin
                                o_cmd.err_set  = 1'b1;
                                o_cmd.err_code = STAT_TRUNC;
                            end else begin
                                o_cmd.lor   = 1'b1;
                                o_cmd.rend  = i_sts.last;
                                o_cmd.close = i_sts.last;
                            end
                        end
                        CLS_LIT: begin
                            o_cmd.emit  = 1'b1;
                            o_cmd.src   = SRC_IN;
                            o_cmd.lor   = 1'b1;
                            o_cmd.rend  = i_sts.last;
                            o_cmd.close = i_sts.last;
                        end
                        CLS_RUN: begin
                            o_cmd.raw_set = 1'b1;
                            if (i_sts.last) begin
                                o_cmd.err_set  = 1'b1;
                                o_cmd.err_code = STAT_TRUNC;
                            end
                        end
                        CLS_SPACE: begin
                            o_cmd.emit = 1'b1;
                            o_cmd.src  = SRC_SPACE;
                        end
                        CLS_PAIR1: begin
                            o_cmd.pair_set = 1'b1;
                            if (i_sts.last) begin
                                o_cmd.err_set  = 1'b1;
                                o_cmd.err_code = STAT_TRUNC;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SECOND: begin
                if (i_sts.out_free) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.src   = SRC_XOR;
                    o_cmd.lor   = 1'b1;
                    o_cmd.rend  = i_sts.last;
                    o_cmd.close = i_sts.last;
                end
            end
            S_COPY: begin
                if (i_sts.out_free) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.src   = SRC_HIST;
                    o_cmd.lor   = i_sts.copy_last;
                    o_cmd.rend  = i_sts.copy_last && i_sts.last;
                    o_cmd.close = i_sts.copy_last && i_sts.last;
                end
            end
            S_ERROR: begin
                if (i_sts.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.src      = SRC_ERR;
                    o_cmd.lor      = 1'b1;
                    o_cmd.rend     = 1'b1;
                    o_cmd.stop_set = 1'b1;
                    o_cmd.close    = i_sts.last;
                end
            end
            default: begin
            end
        endcase
    end

    // copy must hold while the output slot is busy
    a_copy_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY) && !i_sts.out_free |=> (r_state == S_COPY))
        else $error("copy left while output stalled");

endmodule

// ===== rtl/pdlz_dpath.sv =====
`timescale 1ns / 1ps

module pdlz_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pdlz_pkg::t_dp_cmd i_cmd,
    output pdlz_pkg::t_dp_sts o_sts,
    input  logic [7:0]        i_in_byte,
    input  logic              i_in_last,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [7:0]        o_out_byte,
    output logic              o_out_bv,
    output logic              o_out_lor,
    output logic              o_out_rend,
    output pdlz_pkg::t_status o_out_status
);
    import pdlz_pkg::*;

    logic [7:0]         r_in_byte;
    logic               r_in_last;
    logic [HIST_AW-1:0] r_wp;
    logic [HIST_AW-1:0] n_wp;
    logic [CNT_W-1:0]   r_prod;
    logic [CNT_W-1:0]   n_prod;
    logic [3:0]         r_raw;
    logic [3:0]         n_raw;
    logic               r_pair;
    logic               n_pair;
    logic [7:0]         r_high;
    logic               r_stop;
    logic               n_stop;
    t_status            r_err;
    t_status            n_err;
    logic [HIST_AW-1:0] r_dist;
    logic [3:0]         r_cnt;
    logic               r_fwd;
    logic [7:0]         r_fwd_data;

    logic               r_out_valid;
    logic [7:0]         r_out_byte;
    logic               r_out_bv;
    logic               r_out_lor;
    logic               r_out_rend;
    t_status            r_out_status;

    logic [HIST_AW-1:0] pair_dist;
    logic [3:0]         pair_len;
    logic [7:0]         hist_data;
    logic [7:0]         ram_rdata;
    logic [7:0]         emit_byte;
    logic               data_emit;
    logic               hist_emit;
    logic               ram_re;
    logic [HIST_AW-1:0] ram_raddr;
    t_cls               cls;

    assign pair_dist = {r_high[5:0], r_in_byte[7:3]};
    assign pair_len  = {1'b0, r_in_byte[2:0]} + MIN_LEN;
    assign hist_data = r_fwd ? r_fwd_data : ram_rdata;
    assign data_emit = i_cmd.emit && (i_cmd.src != SRC_ERR);
    assign hist_emit = i_cmd.emit && (i_cmd.src == SRC_HIST);
    assign ram_re    = i_cmd.copy_start || hist_emit;
    assign ram_raddr = i_cmd.copy_start ? (r_wp - pair_dist)
                                        : (r_wp + HIST_AW'(1) - r_dist);

    always_comb begin
        priority if (r_stop) begin
            cls = CLS_STOPPED;
        end else if (r_pair) begin
            cls = CLS_PAIR2;
        end else if (r_raw != 4'd0) begin
            cls = CLS_RAW;
        end else if ((r_in_byte == 8'h00) ||
                     ((r_in_byte >= LIT_LOW) && (r_in_byte <= LIT_HIGH))) begin
            cls = CLS_LIT;
        end else if (r_in_byte < LIT_LOW) begin
            cls = CLS_RUN;
        end else if (r_in_byte >= SPACE_LOW) begin
            cls = CLS_SPACE;
        end else begin
            cls = CLS_PAIR1;
        end
    end

    always_comb begin
        o_sts.out_free  = !r_out_valid || i_out_ready;
        o_sts.cls       = cls;
        o_sts.last      = r_in_last;
        o_sts.dist_bad  = (pair_dist == '0) || ({1'b0, pair_dist} > r_prod);
        o_sts.raw_more  = (r_raw > 4'd1);
        o_sts.copy_last = (r_cnt == 4'd1);
    end

    always_comb begin
        unique case (i_cmd.src)
            SRC_IN:    emit_byte = r_in_byte;
            SRC_SPACE: emit_byte = SPACE_BYTE;
            SRC_XOR:   emit_byte = r_in_byte ^ XOR_MASK;
            SRC_HIST:  emit_byte = hist_data;
            SRC_ERR:   emit_byte = 8'h00;
            default:   emit_byte = 8'h00;
        endcase
    end

    always_comb begin
        n_wp   = r_wp;
        n_prod = r_prod;
        n_raw  = r_raw;
        n_pair = r_pair;
        n_stop = r_stop;
        n_err  = r_err;
        if (data_emit) begin
            n_wp = r_wp + HIST_AW'(1);
            if (r_prod < PROD_MAX) begin
                n_prod = r_prod + CNT_W'(1);
            end
        end
        if (i_cmd.raw_set) begin
            n_raw = r_in_byte[3:0];
        end else if (i_cmd.raw_dec) begin
            n_raw = r_raw - 4'd1;
        end
        if (i_cmd.pair_set) begin
            n_pair = 1'b1;
        end else if (i_cmd.pair_clr) begin
            n_pair = 1'b0;
        end
        if (i_cmd.err_set) begin
            n_err = i_cmd.err_code;
        end
        if (i_cmd.stop_set) begin
            n_stop = 1'b1;
        end
        if (i_cmd.close) begin
            n_prod = '0;
            n_raw  = 4'd0;
            n_pair = 1'b0;
            n_stop = 1'b0;
            n_err  = STAT_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_prod      <= '0;
            r_raw       <= 4'd0;
            r_pair      <= 1'b0;
            r_stop      <= 1'b0;
            r_err       <= STAT_OK;
            r_fwd       <= 1'b0;
            r_cnt       <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_wp   <= n_wp;
            r_prod <= n_prod;
            r_raw  <= n_raw;
            r_pair <= n_pair;
            r_stop <= n_stop;
            r_err  <= n_err;
            if (i_cmd.copy_start) begin
                r_cnt <= pair_len;
                r_fwd <= 1'b0;
            end else if (hist_emit) begin
                r_cnt <= r_cnt - 4'd1;
                r_fwd <= (r_dist == HIST_AW'(1));
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last;
        end
        if (i_cmd.pair_set) begin
            r_high <= r_in_byte;
        end
        if (i_cmd.copy_start) begin
            r_dist <= pair_dist;
        end
        if (hist_emit) begin
            r_fwd_data <= hist_data;
        end
        if (i_cmd.emit) begin
            r_out_byte   <= emit_byte;
            r_out_bv     <= data_emit;
            r_out_lor    <= i_cmd.lor;
            r_out_rend   <= i_cmd.rend;
            r_out_status <= (i_cmd.src == SRC_ERR) ? r_err : STAT_OK;
        end
    end

    pdlz_ram #(
        .WIDTH(8),
        .DEPTH(WINDOW_DEPTH)
    ) u_hist (
        .i_clk  (i_clk),
        .i_we   (data_emit),
        .i_waddr(r_wp),
        .i_wdata(emit_byte),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_out_bv     = r_out_bv;
    assign o_out_lor    = r_out_lor;
    assign o_out_rend   = r_out_rend;
    assign o_out_status = r_out_status;

    a_raw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_raw <= RUN_MAX)
        else $error("raw count out of range");

    a_prod_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prod <= PROD_MAX)
        else $error("produced count past window");

    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_status != STAT_OK)
            |-> !r_out_bv && r_out_lor && r_out_rend)
        else $error("error beat without end flags");

endmodule

// ===== rtl/palmdoc_lz77_decompressor_core.sv =====
`timescale 1ns / 1ps

// PalmDoc LZ77 record decoder: one compressed byte per input beat, decoded bytes out one per
// beat. Each input byte is registered when taken and decoded in S_DECODE; literals, raw-run
// bytes and tokens finish there, a space pair emits its second byte from S_SECOND, and a copy
// pair's second byte starts len (3 to 10) output bytes from S_COPY as the 2048-byte history RAM
// is read and written once per output byte. An error adds one error beat, issued from S_ERROR.
// A new byte is taken only after the previous one's output beats are all issued; the output
// register lets the last beat wait while the next byte is taken. m_axis_tlast marks the final
// beat of a record (end of record or error); after an error the rest of the record is consumed without output.
module palmdoc_lz77_decompressor_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [3:0] m_axis_tuser,   // [0] byte_valid, [1] last_of_run, [3:2] status
    output logic       m_axis_tlast
);
    import pdlz_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    t_status out_status;
    logic    out_bv;
    logic    out_lor;

    pdlz_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(s_axis_tvalid),
        .o_in_ready(s_axis_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    pdlz_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_byte   (s_axis_tdata),
        .i_in_last   (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_byte  (m_axis_tdata),
        .o_out_bv    (out_bv),
        .o_out_lor   (out_lor),
        .o_out_rend  (m_axis_tlast),
        .o_out_status(out_status)
    );

    assign m_axis_tuser = {out_status, out_lor, out_bv};

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while previous beat in decode");

endmodule

// ===== dv/tb_palmdoc_lz77_decompressor_core.sv =====
`timescale 1ns / 1ps

module tb_palmdoc_lz77_decompressor_core;

    import pdlz_pkg::*;

    localparam logic [1:0] PAIR_TAG    = 2'b10;
    localparam int         RAND_ITEMS  = 75;
    localparam int         CALM_AFTER  = 55;
    localparam int         LONG_HOLD   = 300;
    localparam int         DRAIN_WAIT  = 20;

    typedef struct {
        logic [7:0] data;
        logic       valid;
        logic       lor;
        logic       rend;
        t_status    stat;
    } t_beat;

    typedef struct {
        logic [7:0] b;
        logic       lst;
        bit         chk;
        int         n;
        logic [7:0] data;
        t_status    stat;
    } t_stim_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] in_byte
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_byte
    logic [3:0] m_axis_tuser;           // [0] byte_valid, [1] last_of_run, [3:2] status
    logic       m_axis_tlast;

    // decoder model state
    logic [7:0]  hist [WINDOW_DEPTH];
    logic [10:0] wr_ptr = '0;
    int unsigned produced = 0;
    int unsigned raw_left = 0;
    bit          pair_wait = 1'b0;
    logic [7:0]  pair_hi = '0;
    bit          halted = 1'b0;

    t_beat       exp_beats[$];
    t_stim_row   dir_rows[$];
    logic [7:0]  rec_bytes[$];
    int          mismatches = 0;
    int          beat_no = 0;
    bit          calm = 1'b0;
    bit          hold_go = 1'b0;
    bit          hold_rx = 1'b0;
    int          rx_gap = 0;

    palmdoc_lz77_decompressor_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic note_mismatch(input string what, input int got, input int want);
        $display("%0t ns beat %0d %s: got %0h, expected %0h", $time, beat_no, what, got, want);
        mismatches++;
    endtask

    task automatic emit_byte(input logic [7:0] v);
        t_beat r;
        hist[wr_ptr] = v;
        wr_ptr++;
        if (produced < WINDOW_DEPTH) produced++;
        r.data = v;
        r.valid = 1'b1;
        r.lor = 1'b0;
        r.rend = 1'b0;
        r.stat = STAT_OK;
        exp_beats.push_back(r);
    endtask

    task automatic close_record();
        produced = 0;
        raw_left = 0;
        pair_wait = 1'b0;
        halted = 1'b0;
    endtask

    // expected beats for one accepted input byte, appended to exp_beats
    task automatic decode_byte(input logic [7:0] b, input logic lst, output int n,
                               output bit live);
        t_beat       r;
        t_status     err;
        logic [15:0] word;
        logic [10:0] cp_dist;
        logic [10:0] src;
        int          len;
        int          base;
        err = STAT_OK;
        base = exp_beats.size();
        live = !halted;
        if (halted) begin
            if (lst) close_record();
            n = 0;
            return;
        end
        if (pair_wait) begin
            word = {pair_hi, b};
            len = int'(word[2:0]) + int'(MIN_LEN);
            cp_dist = word[13:3];
            pair_wait = 1'b0;
            if (cp_dist == 0 || cp_dist > produced) begin
                err = STAT_DIST;
            end else begin
                for (int j = 0; j < len; j++) begin
                    src = wr_ptr - cp_dist;
                    emit_byte(hist[src]);
                end
            end
        end else if (raw_left > 0) begin
            emit_byte(b);
            raw_left--;
            if (lst && raw_left > 0) err = STAT_TRUNC;
        end else if (b == 8'h00 || (b >= LIT_LOW && b <= LIT_HIGH)) begin
            emit_byte(b);
        end else if (b <= RUN_MAX) begin
            raw_left = b;
            if (lst) err = STAT_TRUNC;
        end else if (b >= SPACE_LOW) begin
            emit_byte(SPACE_BYTE);
            emit_byte(b ^ XOR_MASK);
        end else begin
            pair_wait = 1'b1;
            pair_hi = b;
            if (lst) err = STAT_TRUNC;
        end
        if (err != STAT_OK) begin
            r.data = 8'h00;
            r.valid = 1'b0;
            r.lor = 1'b0;
            r.rend = 1'b0;
            r.stat = err;
            exp_beats.push_back(r);
            halted = 1'b1;
        end
        n = exp_beats.size() - base;
        if (n > 0) begin
            exp_beats[$].lor = 1'b1;
            if (lst || err != STAT_OK) exp_beats[$].rend = 1'b1;
        end
        if (lst) close_record();
    endtask

    task automatic send_byte(input logic [7:0] b, input logic lst, output int n,
                             output bit live);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 8);
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= lst;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        decode_byte(b, lst, n, live);
    endtask

    task automatic add_row(input logic [7:0] b, input logic lst, input bit chk, input int n,
                           input logic [7:0] data, input t_status stat);
        t_stim_row row;
        row.b = b;
        row.lst = lst;
        row.chk = chk;
        row.n = n;
        row.data = data;
        row.stat = stat;
        dir_rows.push_back(row);
    endtask

    task automatic push_pair(input logic [10:0] cp_dist, input logic [2:0] len3);
        rec_bytes.push_back({PAIR_TAG, cp_dist[10:5]});
        rec_bytes.push_back({cp_dist[4:0], len3});
    endtask

    // mostly well-formed records; some bad distances, stray bytes and cut-off endings
    task automatic build_record();
        int tokens;
        int made;
        int cls;
        int cnt;
        int cut;
        rec_bytes.delete();
        made = 0;
        tokens = $urandom_range(1, 12);
        repeat (tokens) begin
            cls = $urandom_range(0, 19);
            if (cls < 5) begin
                rec_bytes.push_back($urandom_range(0, 3) == 0 ? 8'h00
                                    : 8'($urandom_range(LIT_LOW, LIT_HIGH)));
                made += 1;
            end else if (cls < 9) begin
                rec_bytes.push_back(8'($urandom_range(SPACE_LOW, 8'hff)));
                made += 2;
            end else if (cls < 13) begin
                cnt = $urandom_range(1, RUN_MAX);
                rec_bytes.push_back(8'(cnt));
                repeat (cnt) rec_bytes.push_back(8'($urandom_range(0, 255)));
                made += cnt;
            end else if (cls < 18 && made > 0) begin
                cnt = $urandom_range(0, 7);
                push_pair(11'($urandom_range(1, made)), 3'(cnt));
                made += cnt + int'(MIN_LEN);
            end else if (cls < 19) begin
                push_pair($urandom_range(0, 1) ? 11'd0
                          : 11'($urandom_range(made + 1, WINDOW_DEPTH - 1)),
                          3'($urandom_range(0, 7)));
            end else begin
                rec_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
        if (rec_bytes.size() > 1 && $urandom_range(0, 7) == 0) begin
            cut = $urandom_range(1, rec_bytes.size() - 1);
            while (rec_bytes.size() > cut) void'(rec_bytes.pop_back());
        end
    endtask

    always @(negedge i_clk) begin
        if (hold_rx) begin
            m_axis_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            m_axis_tready <= 1'b0;
            rx_gap--;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            rx_gap = $urandom_range(0, 7);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        wait (hold_go);
        @(posedge i_clk);
        hold_rx = 1'b1;
        repeat (LONG_HOLD) @(posedge i_clk);
        hold_rx = 1'b0;
    end

    always @(posedge i_clk) begin
        t_beat w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (exp_beats.size() == 0) begin
                note_mismatch("unexpected beat, data", m_axis_tdata, 0);
            end else begin
                w = exp_beats.pop_front();
                if (m_axis_tdata !== w.data) note_mismatch("out_byte", m_axis_tdata, w.data);
                if (m_axis_tuser[0] !== w.valid)
                    note_mismatch("byte_valid", m_axis_tuser[0], w.valid);
                if (m_axis_tuser[1] !== w.lor)
                    note_mismatch("last_of_run", m_axis_tuser[1], w.lor);
                if (m_axis_tlast !== w.rend) note_mismatch("record_end", m_axis_tlast, w.rend);
                if (m_axis_tuser[3:2] !== w.stat)
                    note_mismatch("status", m_axis_tuser[3:2], w.stat);
            end
            beat_no++;
        end
    end

    initial begin
        #2_000_000;
        $display("palmdoc_lz77_decompressor_core verification failed");
        $finish;
    end

    initial begin
        int n;
        int live_items;
        bit live;
        foreach (hist[i]) hist[i] = 8'h00;

        // literals, spaces, raw run, overlapped copy, then a bad distance
        add_row(8'h00, 1'b0, 1, 1, 8'h00, STAT_OK);
        add_row(8'h7f, 1'b0, 1, 1, 8'h7f, STAT_OK);
        add_row(8'h09, 1'b0, 1, 1, 8'h09, STAT_OK);
        add_row(8'hc1, 1'b0, 1, 2, 8'h41, STAT_OK);
        add_row(8'hff, 1'b0, 1, 2, 8'h7f, STAT_OK);
        add_row(8'h03, 1'b0, 1, 0, 8'h00, STAT_OK);
        add_row(8'h80, 1'b0, 1, 1, 8'h80, STAT_OK);
        add_row(8'hfe, 1'b0, 1, 1, 8'hfe, STAT_OK);
        add_row(8'h01, 1'b0, 1, 1, 8'h01, STAT_OK);
        add_row(8'h80, 1'b0, 1, 0, 8'h00, STAT_OK);
        add_row(8'h0f, 1'b0, 1, 10, 8'h01, STAT_OK);
        add_row(8'hbf, 1'b0, 1, 0, 8'h00, STAT_OK);
        add_row(8'hf8, 1'b0, 1, 1, 8'h00, STAT_DIST);
        add_row(8'h41, 1'b0, 1, 0, 8'h00, STAT_OK);
        add_row(8'h42, 1'b1, 1, 0, 8'h00, STAT_OK);
        // raw run cut short by end of record
        add_row(8'h02, 1'b0, 1, 0, 8'h00, STAT_OK);
        add_row(8'h55, 1'b1, 1, 2, 8'h00, STAT_TRUNC);
        // run token as last byte, pair head as last byte
        add_row(8'h05, 1'b1, 1, 1, 8'h00, STAT_TRUNC);
        add_row(8'h80, 1'b1, 1, 1, 8'h00, STAT_TRUNC);
        // copy before anything was produced
        add_row(8'h80, 1'b0, 1, 0, 8'h00, STAT_OK);
        add_row(8'h08, 1'b0, 1, 1, 8'h00, STAT_DIST);
        add_row(8'h41, 1'b1, 1, 0, 8'h00, STAT_OK);
        // zero distance on the closing byte
        add_row(8'h61, 1'b0, 1, 1, 8'h61, STAT_OK);
        add_row(8'h80, 1'b0, 0, 0, 8'h00, STAT_OK);
        add_row(8'h00, 1'b1, 1, 1, 8'h00, STAT_DIST);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            send_byte(dir_rows[i].b, dir_rows[i].lst, n, live);
            if (dir_rows[i].chk) begin
                if (n != dir_rows[i].n) begin
                    note_mismatch("directed beat count", n, dir_rows[i].n);
                end else if (n > 0) begin
                    if (exp_beats[$].data !== dir_rows[i].data)
                        note_mismatch("directed last data", exp_beats[$].data,
                                      dir_rows[i].data);
                    if (exp_beats[$].stat !== dir_rows[i].stat)
                        note_mismatch("directed last status", exp_beats[$].stat,
                                      dir_rows[i].stat);
                end
            end
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        wait (exp_beats.size() == 0);
        hold_go = 1'b1;

        live_items = 0;
        while (live_items < RAND_ITEMS) begin
            build_record();
            foreach (rec_bytes[i]) begin
                send_byte(rec_bytes[i], i == rec_bytes.size() - 1, n, live);
                if (live) live_items++;
                if (live_items >= CALM_AFTER) calm = 1'b1;
            end
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        wait (exp_beats.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("palmdoc_lz77_decompressor_core verification clean");
        end else begin
            $display("palmdoc_lz77_decompressor_core verification failed");
        end
        $finish;
    end

endmodule
